FILE: rtl/core/sfd_pkg.sv
// ---------------------------------------------------------------------------
// sfd_pkg
// Shared types and constants for the serial frame deframer.
// ---------------------------------------------------------------------------
package sfd_pkg;

	localparam int MAX_WORDS_DEF = 7;
	localparam int MIN_LEN       = 6;

	localparam logic [7:0] START_MARKER_RST = 8'd2;
	localparam logic [7:0] END_MARKER_RST   = 8'd3;
	localparam logic [7:0] OWN_ADDRESS_RST  = 8'd0;

	typedef enum logic [1:0] {
		REG_START_MARKER = 2'd0,
		REG_END_MARKER   = 2'd1,
		REG_OWN_ADDRESS  = 2'd2,
		REG_NONE         = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_BAD_END = 2'd1,
		STAT_FOREIGN = 2'd2
	} stat_t;

	typedef enum logic [2:0] {
		S_HUNT,
		S_LEN,
		S_BODY,
		S_HEAD,
		S_WORD
	} state_t;

	// byte positions within a frame
	localparam int POS_FIRST = 2;
	localparam int POS_RCV   = 2;
	localparam int POS_CMD   = 3;
	localparam int POS_FMT   = 4;

	typedef struct packed {
		logic load_len;
		logic body_wr;
		logic close;
		logic word_inc;
		logic sel_word;
	} cmd_t;

	typedef struct packed {
		logic start_hit;
		logic len_ok;
		logic at_end;
		logic hdr_last;
		logic word_last;
	} sts_t;

endpackage

FILE: rtl/core/sfd_ctrl.sv
// ---------------------------------------------------------------------------
// sfd_ctrl
// Frame state machine: hunt, length, body, then header and word output.
// ---------------------------------------------------------------------------
module sfd_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	input  logic          m_tready,
	input  sfd_pkg::sts_t sts,
	output logic          s_tready,
	output logic          m_tvalid,
	output sfd_pkg::cmd_t cmd
);
	import sfd_pkg::*;

	state_t state_q;
	state_t state_nx;
	logic   s_acc;
	logic   m_acc;

	assign s_acc = s_tvalid && s_tready;
	assign m_acc = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_HUNT;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_HUNT: begin
				if (s_acc && sts.start_hit) state_nx = S_LEN;
			end
			S_LEN: begin
				if (s_acc) state_nx = sts.len_ok ? S_BODY : S_HUNT;
			end
			S_BODY: begin
				if (s_acc && sts.at_end) state_nx = S_HEAD;
			end
			S_HEAD: begin
				if (m_acc) state_nx = sts.hdr_last ? S_HUNT : S_WORD;
			end
			S_WORD: begin
				if (m_acc && sts.word_last) state_nx = S_HUNT;
			end
			default: state_nx = S_HUNT;
		endcase
	end

	always_comb begin
		s_tready     = 1'b0;
		m_tvalid     = 1'b0;
		cmd          = '0;
		unique case (state_q)
			S_HUNT: begin
				s_tready = 1'b1;
			end
			S_LEN: begin
				s_tready     = 1'b1;
				cmd.load_len = s_tvalid && sts.len_ok;
			end
			S_BODY: begin
				s_tready    = 1'b1;
				cmd.body_wr = s_tvalid && !sts.at_end;
				cmd.close   = s_tvalid && sts.at_end;
			end
			S_HEAD: begin
				m_tvalid = 1'b1;
			end
			S_WORD: begin
				m_tvalid     = 1'b1;
				cmd.sel_word = 1'b1;
				cmd.word_inc = m_tready;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

`ifndef ASSERT_OFF
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input and output requests open together");

	a_head_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_HEAD) |-> ($past(state_q) == S_BODY || $past(state_q) == S_HEAD))
		else $error("header output without a closed frame");
`endif

endmodule

FILE: rtl/core/sfd_datapath.sv
// ---------------------------------------------------------------------------
// sfd_datapath
// Frame field registers, word store and result formatting.
// ---------------------------------------------------------------------------
module sfd_datapath #(
	parameter int MAX_WORDS = sfd_pkg::MAX_WORDS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [7:0]    rx_byte,
	input  logic [7:0]    start_marker,
	input  logic [7:0]    end_marker,
	input  logic [7:0]    own_address,
	input  sfd_pkg::cmd_t cmd,
	output sfd_pkg::sts_t sts,
	output logic          kind,
	output logic [1:0]    status,
	output logic [7:0]    command,
	output logic [7:0]    data_format,
	output logic [4:0]    frame_length,
	output logic [2:0]    word_index,
	output logic [15:0]   word_value,
	output logic          last
);
	import sfd_pkg::*;

	localparam int         LEN_W  = $clog2(2 * MAX_WORDS + MIN_LEN + 1);
	localparam int         AW     = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
	localparam int         NW_W   = $clog2(MAX_WORDS + 1);
	localparam logic [7:0] MaxLen = 8'(2 * MAX_WORDS + MIN_LEN);

	logic [LEN_W-1:0] len_q;
	logic [LEN_W-1:0] pos_q;
	logic [7:0]       rcv_q;
	logic [7:0]       cmd_q;
	logic [7:0]       fmt_q;
	logic [7:0]       low_q;
	stat_t            stat_q;
	logic [NW_W-1:0]  widx_q;
	logic [15:0]      wst_q [MAX_WORDS];

	logic [LEN_W:0]   pos_nx;
	logic [LEN_W-1:0] nwords;
	logic [LEN_W-1:0] wr_w;
	logic [LEN_W-1:0] widx_ext;

	assign pos_nx   = {1'b0, pos_q} + (LEN_W+1)'(1);
	assign nwords   = {1'b0, len_q[LEN_W-1:1]} - LEN_W'(MIN_LEN / 2);
	assign wr_w     = {1'b0, pos_q[LEN_W-1:1]} - LEN_W'(MIN_LEN / 2);
	assign widx_ext = LEN_W'(widx_q);

	assign sts.start_hit = (rx_byte == start_marker);
	assign sts.len_ok    = (rx_byte >= 8'(MIN_LEN)) && !rx_byte[0] && (rx_byte <= MaxLen);
	assign sts.at_end    = (pos_nx >= {1'b0, len_q});
	assign sts.hdr_last  = (stat_q != STAT_OK) || (nwords == '0);
	assign sts.word_last = (widx_ext + LEN_W'(1) == nwords);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= '0;
			pos_q  <= '0;
			rcv_q  <= '0;
			cmd_q  <= '0;
			fmt_q  <= '0;
			low_q  <= '0;
			stat_q <= STAT_OK;
			widx_q <= '0;
		end else begin
			if (cmd.load_len) begin
				len_q <= LEN_W'(rx_byte);
				pos_q <= LEN_W'(POS_FIRST);
			end
			if (cmd.body_wr) begin
				pos_q <= pos_nx[LEN_W-1:0];
				if (pos_q == LEN_W'(POS_RCV)) begin
					rcv_q <= rx_byte;
				end else if (pos_q == LEN_W'(POS_CMD)) begin
					cmd_q <= rx_byte;
				end else if (pos_q == LEN_W'(POS_FMT)) begin
					fmt_q <= rx_byte;
				end else if (pos_q[0]) begin
					low_q <= rx_byte;
				end
			end
			if (cmd.close) begin
				widx_q <= '0;
				if (rx_byte != end_marker) begin
					stat_q <= STAT_BAD_END;
				end else if (rcv_q != own_address) begin
					stat_q <= STAT_FOREIGN;
				end else begin
					stat_q <= STAT_OK;
				end
			end
			if (cmd.word_inc) begin
				widx_q <= widx_q + NW_W'(1);
			end
		end
	end

	// word store: no reset, every emitted word is written earlier in the frame
	always_ff @(posedge clk) begin
		if (cmd.body_wr && !pos_q[0] && (pos_q > LEN_W'(POS_FMT))
				&& (wr_w < LEN_W'(MAX_WORDS))) begin
			wst_q[wr_w[AW-1:0]] <= {rx_byte, low_q};
		end
	end

	assign kind         = cmd.sel_word;
	assign status       = cmd.sel_word ? STAT_OK : stat_q;
	assign command      = cmd_q;
	assign data_format  = fmt_q;
	assign frame_length = 5'(len_q);
	assign word_index   = cmd.sel_word ? 3'(widx_q) : 3'd0;
	assign word_value   = cmd.sel_word ? wst_q[widx_q[AW-1:0]] : 16'd0;
	assign last         = cmd.sel_word ? sts.word_last : sts.hdr_last;

`ifndef ASSERT_OFF
	a_word_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sel_word |-> (widx_ext < nwords))
		else $error("word index past frame word count");

	a_close_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.close |=> (widx_q == '0))
		else $error("word index not cleared at frame close");
`endif

endmodule

FILE: rtl/core/serial_frame_deframer_unit.sv
// Latency: the first result of a frame is offered the cycle after its end byte is taken.
// Throughput: one byte per cycle while receiving; a good frame then drains header and
// words (up to MAX_WORDS+1 results), one per cycle while m_tready is high, input held off.
// Reset: arst_n clears the state machine and registers; markers return to 2/3, address 0.
// ---------------------------------------------------------------------------
// serial_frame_deframer_unit
// Serial byte deframer with APB register port and stream in/out.
// ---------------------------------------------------------------------------
module serial_frame_deframer_unit #(
	parameter int MAX_WORDS = sfd_pkg::MAX_WORDS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// APB
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // rx_byte
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,  // status[1:0], command[9:2], data_format[17:10],
	                              // frame_length[22:18], word_index[25:23],
	                              // word_value[41:26], zero pad
	output logic        m_tuser,  // kind
	output logic        m_tlast   // last
);
	import sfd_pkg::*;

	logic [7:0]  start_q;
	logic [7:0]  end_q;
	logic [7:0]  addr_q;
	reg_idx_t    ridx;
	logic        wr_en;
	cmd_t        cmd;
	sts_t        sts;
	logic [1:0]  status;
	logic [7:0]  command;
	logic [7:0]  data_format;
	logic [4:0]  frame_length;
	logic [2:0]  word_index;
	logic [15:0] word_value;

	assign pready = 1'b1;
	assign ridx   = reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= START_MARKER_RST;
			end_q   <= END_MARKER_RST;
			addr_q  <= OWN_ADDRESS_RST;
		end else if (wr_en) begin
			unique case (ridx)
				REG_START_MARKER: start_q <= pwdata[7:0];
				REG_END_MARKER:   end_q   <= pwdata[7:0];
				REG_OWN_ADDRESS:  addr_q  <= pwdata[7:0];
				default:          ;
			endcase
		end
	end

	always_comb begin
		unique case (ridx)
			REG_START_MARKER: prdata = {24'd0, start_q};
			REG_END_MARKER:   prdata = {24'd0, end_q};
			REG_OWN_ADDRESS:  prdata = {24'd0, addr_q};
			default:          prdata = 32'd0;
		endcase
	end

	sfd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.cmd      (cmd)
	);

	sfd_datapath #(
		.MAX_WORDS (MAX_WORDS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.rx_byte      (s_tdata),
		.start_marker (start_q),
		.end_marker   (end_q),
		.own_address  (addr_q),
		.cmd          (cmd),
		.sts          (sts),
		.kind         (m_tuser),
		.status       (status),
		.command      (command),
		.data_format  (data_format),
		.frame_length (frame_length),
		.word_index   (word_index),
		.word_value   (word_value),
		.last         (m_tlast)
	);

	assign m_tdata = {6'd0, word_value, word_index, frame_length, data_format, command, status};

endmodule

FILE: dv/serial_frame_deframer_unit_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Serial frame deframer unit testbench
// Byte-stream stimulus (directed frames, then random frames mixed with noise
// and broken frames) under several marker/address settings written over APB.
// A local deframer model predicts each result; results are checked in order.
// ---------------------------------------------------------------------------
module serial_frame_deframer_unit_test;
	import sfd_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 20;
	localparam int PHASE_BYTES  = 12;

	typedef struct packed {
		logic        kind;
		stat_t       status;
		logic [7:0]  command;
		logic [7:0]  data_format;
		logic [4:0]  frame_length;
		logic [2:0]  word_index;
		logic [15:0] word_value;
		logic        last;
	} frame_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;

	serial_frame_deframer_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	logic [7:0]    rx_q[$];
	frame_result_t frame_results_q[$];
	int            src_idle_pct = 0;
	int            sink_stall_pct = 0;
	int            error_count = 0;
	int            cycle_count = 0;

	// marker/address copies
	logic [7:0] start_mk = START_MARKER_RST;
	logic [7:0] end_mk   = END_MARKER_RST;
	logic [7:0] own_addr = OWN_ADDRESS_RST;

	// deframer model state
	state_t      df_state = S_HUNT;
	int          df_pos = 0;
	logic [4:0]  df_len = '0;
	logic [7:0]  df_rcv = '0;
	logic [7:0]  df_cmd = '0;
	logic [7:0]  df_fmt = '0;
	logic [7:0]  df_low = '0;
	logic [15:0] df_words[MAX_WORDS_DEF];

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic frame_result_t header_result(stat_t st, logic last);
		frame_result_t r;
		r = '0;
		r.status       = st;
		r.command      = df_cmd;
		r.data_format  = df_fmt;
		r.frame_length = df_len;
		r.last         = last;
		return r;
	endfunction

	task automatic deframe_byte(input logic [7:0] b);
		int nwords;
		frame_result_t r;
		case (df_state)
			S_HUNT: begin
				if (b == start_mk)
					df_state = S_LEN;
			end
			S_LEN: begin
				if (b < MIN_LEN || b[0] || (int'(b) - MIN_LEN) / 2 > MAX_WORDS_DEF) begin
					df_state = S_HUNT;
				end else begin
					df_len   = b[4:0];
					df_pos   = POS_FIRST;
					df_state = S_BODY;
				end
			end
			default: begin
				if (df_pos + 1 >= int'(df_len)) begin
					nwords   = (int'(df_len) - MIN_LEN) / 2;
					df_state = S_HUNT;
					df_pos   = 0;
					if (b != end_mk) begin
						frame_results_q.push_back(header_result(STAT_BAD_END, 1'b1));
					end else if (df_rcv != own_addr) begin
						frame_results_q.push_back(header_result(STAT_FOREIGN, 1'b1));
					end else begin
						frame_results_q.push_back(header_result(STAT_OK, nwords == 0));
						for (int i = 0; i < nwords; i++) begin
							r            = header_result(STAT_OK, i + 1 == nwords);
							r.kind       = 1'b1;
							r.word_index = i[2:0];
							r.word_value = df_words[i];
							frame_results_q.push_back(r);
						end
					end
				end else begin
					if (df_pos == POS_RCV)
						df_rcv = b;
					else if (df_pos == POS_CMD)
						df_cmd = b;
					else if (df_pos == POS_FMT)
						df_fmt = b;
					else if (((df_pos - 5) & 1) == 0)
						df_low = b;
					else if ((df_pos - 6) / 2 < MAX_WORDS_DEF)
						df_words[(df_pos - 6) / 2] = {b, df_low};
					df_pos++;
				end
			end
		endcase
	endtask

	task automatic check_result();
		frame_result_t exp_r;
		frame_result_t got;
		got.kind         = m_tuser;
		got.status       = stat_t'(m_tdata[1:0]);
		got.command      = m_tdata[9:2];
		got.data_format  = m_tdata[17:10];
		got.frame_length = m_tdata[22:18];
		got.word_index   = m_tdata[25:23];
		got.word_value   = m_tdata[41:26];
		got.last         = m_tlast;
		if (frame_results_q.size() == 0) begin
			$error("unexpected result: tdata %h tuser %b tlast %b", m_tdata, m_tuser, m_tlast);
			error_count++;
		end else begin
			exp_r = frame_results_q.pop_front();
			if (got.kind !== exp_r.kind) begin
				$error("kind: expected %0d, got %0d", exp_r.kind, got.kind);
				error_count++;
			end
			if (got.status !== exp_r.status) begin
				$error("status: expected %0d, got %0d", exp_r.status, got.status);
				error_count++;
			end
			if (got.command !== exp_r.command) begin
				$error("command: expected %0d, got %0d", exp_r.command, got.command);
				error_count++;
			end
			if (got.data_format !== exp_r.data_format) begin
				$error("data_format: expected %0d, got %0d", exp_r.data_format,
					got.data_format);
				error_count++;
			end
			if (got.frame_length !== exp_r.frame_length) begin
				$error("frame_length: expected %0d, got %0d", exp_r.frame_length,
					got.frame_length);
				error_count++;
			end
			if (got.word_index !== exp_r.word_index) begin
				$error("word_index: expected %0d, got %0d", exp_r.word_index,
					got.word_index);
				error_count++;
			end
			if (got.word_value !== exp_r.word_value) begin
				$error("word_value: expected %0d, got %0d", $signed(exp_r.word_value),
					$signed(got.word_value));
				error_count++;
			end
			if (got.last !== exp_r.last) begin
				$error("last: expected %0d, got %0d", exp_r.last, got.last);
				error_count++;
			end
		end
	endtask

	// request driver
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || s_tready) begin
			if (rx_q.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
				s_tvalid <= 1'b1;
				s_tdata  <= rx_q.pop_front();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		m_tready <= $urandom_range(99) >= sink_stall_pct;
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				deframe_byte(s_tdata);
			if (m_tvalid && m_tready)
				check_result();
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic apb_write(input reg_idx_t idx, input logic [7:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {24'($urandom_range(24'hFFFFFF)), val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_START_MARKER: start_mk = val;
			REG_END_MARKER:   end_mk   = val;
			REG_OWN_ADDRESS:  own_addr = val;
			default: ;
		endcase
	endtask

	task automatic wait_idle();
		while (rx_q.size() > 0 || s_tvalid)
			@(posedge clk);
		while (frame_results_q.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [15:0] pick_word();
		case ($urandom_range(7))
			0: return 16'h0000;
			1: return 16'h7FFF;
			2: return 16'h8000;
			3: return 16'hFFFF;
			default: return 16'($urandom_range(16'hFFFF));
		endcase
	endfunction

	// whole frame of len bytes, start marker to closing byte
	task automatic push_frame(input int len, input logic [7:0] rcv, input logic [7:0] tail);
		logic [15:0] w;
		rx_q.push_back(start_mk);
		rx_q.push_back(len[7:0]);
		rx_q.push_back(rcv);
		rx_q.push_back(8'($urandom_range(255)));
		rx_q.push_back(8'($urandom_range(255)));
		for (int i = 0; i < (len - MIN_LEN) / 2; i++) begin
			w = pick_word();
			rx_q.push_back(w[7:0]);
			rx_q.push_back(w[15:8]);
		end
		rx_q.push_back(tail);
	endtask

	task automatic fill_random_phase();
		int sent;
		int len;
		int pick;
		int n_noise;
		logic [7:0] rcv;
		logic [7:0] tail;
		sent = 0;
		while (sent < PHASE_BYTES) begin
			pick = $urandom_range(99);
			if (pick < 75) begin
				len  = MIN_LEN + 2 * $urandom_range(MAX_WORDS_DEF);
				rcv  = ($urandom_range(3) != 0) ? own_addr : 8'($urandom_range(255));
				tail = ($urandom_range(6) != 0) ? end_mk : 8'($urandom_range(255));
				push_frame(len, rcv, tail);
				sent += len;
			end else if (pick < 87) begin
				rx_q.push_back(start_mk);
				rx_q.push_back(8'($urandom_range(255)));
				sent += 2;
			end else begin
				n_noise = $urandom_range(1, 4);
				repeat (n_noise) rx_q.push_back(8'($urandom_range(255)));
				sent += n_noise;
			end
		end
	endtask

	task automatic set_idling(input int mode);
		case (mode % 4)
			0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
			1: begin src_idle_pct = 45; sink_stall_pct = 0;  end
			2: begin src_idle_pct = 0;  sink_stall_pct = 45; end
			default: begin src_idle_pct = 36; sink_stall_pct = 36; end
		endcase
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// write to an unmapped register has no effect
		apb_write(REG_NONE, 8'hAA);
		set_idling(3);

		// noise, start marker as length byte, then header-only frame
		rx_q = {rx_q, 8'h55, start_mk, start_mk, start_mk, 8'd6, own_addr, 8'hFF, 8'h00,
			end_mk};
		// odd, oversized and extreme lengths
		rx_q = {rx_q, start_mk, 8'd7, start_mk, 8'd22, start_mk, 8'hFF, start_mk, 8'h00};
		// longest frame, extreme words, markers inside the body
		rx_q = {rx_q, start_mk, 8'd20, own_addr, 8'hA5, 8'h5A, 8'h00, 8'h00, 8'hFF, 8'h7F,
			8'h00, 8'h80, 8'hFF, 8'hFF, start_mk, start_mk, end_mk, end_mk, 8'h34, 8'h12,
			end_mk};
		// foreign receiver; foreign with bad end; bad end alone
		rx_q = {rx_q, start_mk, 8'd8, 8'h01, 8'h10, 8'h20, 8'h11, 8'h22, end_mk};
		rx_q = {rx_q, start_mk, 8'd8, 8'h01, 8'h30, 8'h40, 8'h33, 8'h44, 8'h04};
		rx_q = {rx_q, start_mk, 8'd6, own_addr, 8'h50, 8'h60, 8'hFF};
		wait_idle();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					apb_write(REG_START_MARKER, 8'h00);
					apb_write(REG_END_MARKER, 8'hFF);
					apb_write(REG_OWN_ADDRESS, 8'hFF);
				end
				1: begin
					apb_write(REG_START_MARKER, 8'hFF);
					apb_write(REG_END_MARKER, 8'h00);
					apb_write(REG_OWN_ADDRESS, 8'h00);
				end
				default: begin
					apb_write(REG_START_MARKER, 8'($urandom_range(255)));
					apb_write(REG_END_MARKER, 8'($urandom_range(255)));
					apb_write(REG_OWN_ADDRESS, 8'($urandom_range(255)));
				end
			endcase
			set_idling(ph);
			fill_random_phase();
			wait_idle();
		end

		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

FILE: serial_frame_deframer_unit.f
rtl/core/sfd_pkg.sv
rtl/core/sfd_ctrl.sv
rtl/core/sfd_datapath.sv
rtl/core/serial_frame_deframer_unit.sv
dv/serial_frame_deframer_unit_test.sv
